>>> hdl/xted_pkg.sv
// ----------------------------------------------------------------------------
// xted_pkg
// Shared types, constants and helper functions of the XML text entity decoder.
// ----------------------------------------------------------------------------
package xted_pkg;

  localparam int ENTITY_MAX_DEF = 32;
  // entity length counter, wide enough for the largest entity bound plus overflow mark
  localparam int LEN_W          = 6;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;

  localparam logic [31:0] CODE_SAT = 32'h8000_0000;

  localparam int NUM_NAMES = 5;
  localparam logic [2:0] NAME_LT   = 3'd0;
  localparam logic [2:0] NAME_GT   = 3'd1;
  localparam logic [2:0] NAME_AMP  = 3'd2;
  localparam logic [2:0] NAME_QUOT = 3'd3;
  localparam logic [2:0] NAME_APOS = 3'd4;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_ERR,
    CMD_END,
    CMD_REPLAY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic              err;
    logic              ws;
    logic              end_after;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  function automatic logic [2:0] name_len(input logic [2:0] k);
    case (k)
      NAME_LT:   name_len = 3'd2;
      NAME_GT:   name_len = 3'd2;
      NAME_AMP:  name_len = 3'd3;
      NAME_QUOT: name_len = 3'd4;
      NAME_APOS: name_len = 3'd4;
      default:   name_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] name_char(input logic [2:0] k, input logic [1:0] pos);
    logic [31:0] s;
    case (k)
      NAME_LT:   s = {"lt", 16'h0000};
      NAME_GT:   s = {"gt", 16'h0000};
      NAME_AMP:  s = {"amp", 8'h00};
      NAME_QUOT: s = "quot";
      NAME_APOS: s = "apos";
      default:   s = 32'h0;
    endcase
    case (pos)
      2'd0:    name_char = s[31:24];
      2'd1:    name_char = s[23:16];
      2'd2:    name_char = s[15:8];
      default: name_char = s[7:0];
    endcase
  endfunction

  function automatic logic [7:0] name_value(input logic [2:0] k);
    case (k)
      NAME_LT:   name_value = CH_LT;
      NAME_GT:   name_value = CH_GT;
      NAME_AMP:  name_value = CH_AMP;
      NAME_QUOT: name_value = CH_QUOT;
      NAME_APOS: name_value = CH_APOS;
      default:   name_value = 8'h00;
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  // {ok, value}
  function automatic logic [4:0] digit_val(input logic [7:0] b, input logic hex);
    if (b >= 8'h30 && b <= 8'h39) begin
      digit_val = {1'b1, 4'(b - 8'h30)};
    end else if (hex && b >= 8'h61 && b <= 8'h66) begin
      digit_val = {1'b1, 4'(b - 8'h57)};
    end else if (hex && b >= 8'h41 && b <= 8'h46) begin
      digit_val = {1'b1, 4'(b - 8'h37)};
    end else begin
      digit_val = 5'b0;
    end
  endfunction

endpackage

>>> hdl/xml_text_entity_decoder.sv
// ----------------------------------------------------------------------------
// xml_text_entity_decoder
// XML element text decoder: character entities in, decoded bytes out.
// ----------------------------------------------------------------------------
// A byte is taken whenever the command queue has room and, inside an entity, no
// replay runs; plain text, closed known and numeric entities, error results and
// end markers each make one result in the output stage, bytes inside an entity
// make none there, and an entity closed by end of buffer adds its own end marker.
// An unknown or overflowed entity of n stored bytes is replayed by the output
// stage as command fetch, '&', one entity store read per byte and ';', and while
// such a replay runs the input stalls on bytes that fall inside the next entity,
// because the entity store holds one entity at a time. A four-entry queue lets
// input and output stall independently; the sustained rate is about one byte per
// cycle on plain text while the output keeps up, lower with many unknown entities.
module xml_text_entity_decoder #(
  parameter int ENTITY_MAX = xted_pkg::ENTITY_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       end_of_text,
  output logic       node_whitespace,
  output logic       entity_error
);
  import xted_pkg::*;

  localparam int AW = $clog2(ENTITY_MAX);

  cmd_t          push_cmd;
  cmd_t          head;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  logic          replay_done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_rd_en;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  xted_front #(.ENTITY_MAX(ENTITY_MAX)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .cmd           (push_cmd),
    .cmd_push      (push),
    .cmd_full      (full),
    .replay_done   (replay_done),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  xted_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  xted_ram #(.WIDTH(8), .DEPTH(ENTITY_MAX)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .rd_en (ram_rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  xted_back #(.ENTITY_MAX(ENTITY_MAX)) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .replay_done     (replay_done),
    .ram_rd_en       (ram_rd_en),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .byte_valid      (byte_valid),
    .end_of_text     (end_of_text),
    .node_whitespace (node_whitespace),
    .entity_error    (entity_error)
  );

endmodule

>>> hdl/xted_ram.sv
// ----------------------------------------------------------------------------
// xted_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module xted_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/xted_queue.sv
// ----------------------------------------------------------------------------
// xted_queue
// Short command queue between the classifying front end and the output back end.
// ----------------------------------------------------------------------------
module xted_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xted_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output xted_pkg::cmd_t  head,
  output logic            empty
);
  import xted_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slots [QUEUE_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : QAW'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : QAW'(rptr + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= CW'(count + 1'b1);
        2'b01:   count <= CW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/xted_front.sv
// ----------------------------------------------------------------------------
// xted_front
// Accepts text bytes, tracks text/entity mode, collects entity bytes into the
// entity store and turns each completed step into one command for the back end.
// ----------------------------------------------------------------------------
module xted_front #(
  parameter int ENTITY_MAX = xted_pkg::ENTITY_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_buffer,
  output xted_pkg::cmd_t                cmd,
  output logic                          cmd_push,
  input  logic                          cmd_full,
  input  logic                          replay_done,
  output logic                          ram_we,
  output logic [$clog2(ENTITY_MAX)-1:0] ram_waddr,
  output logic [7:0]                    ram_wdata
);
  import xted_pkg::*;

  typedef enum logic {
    M_TEXT,
    M_ENTITY
  } mode_t;

  mode_t                mode;
  logic [LEN_W-1:0]     ent_len;
  logic [31:0]          acc;
  logic                 stopped;
  logic                 has_digit;
  logic                 is_num;
  logic                 is_hex;
  logic [NUM_NAMES-1:0] match;
  logic                 nonempty;
  logic                 blank;
  logic                 busy;

  logic                 nonempty_next;
  logic                 blank_next;
  logic [31:0]          acc_next;
  logic                 accept;
  logic                 store_go;
  logic                 digit_go;
  logic                 hex_now;
  logic [4:0]           dv;
  logic [36:0]          prod;
  logic                 named_hit;
  logic [7:0]           named_ch;

  assign in_ready  = !cmd_full && !(mode == M_ENTITY && busy);
  assign accept    = in_valid && in_ready;
  assign store_go  = accept && !end_of_buffer && mode == M_ENTITY && data_byte != CH_SEMI
                     && ent_len < LEN_W'(ENTITY_MAX);
  assign ram_we    = store_go;
  assign ram_waddr = ent_len[$clog2(ENTITY_MAX)-1:0];
  assign ram_wdata = data_byte;

  // hex is chosen by the byte after '#', which may be the one arriving now
  assign hex_now  = (ent_len == LEN_W'(1)) ? (data_byte == CH_X) : is_hex;
  assign dv       = digit_val(data_byte, hex_now);
  assign digit_go = store_go && ent_len != '0 && is_num && !stopped
                    && !(hex_now && ent_len == LEN_W'(1));
  // times 16 or times 10 as shifts and adds
  assign prod     = hex_now ? ({1'b0, acc, 4'h0} + 37'(dv[3:0]))
                            : ({2'b00, acc, 3'h0} + {4'h0, acc, 1'b0} + 37'(dv[3:0]));
  assign acc_next = acc[31] ? acc : ((prod[36:31] != '0) ? CODE_SAT : prod[31:0]);

  always_comb begin
    named_hit = 1'b0;
    named_ch  = 8'h00;
    for (int k = 0; k < NUM_NAMES; k++) begin
      if (match[k] && ent_len == LEN_W'(name_len(3'(k)))) begin
        named_hit = 1'b1;
        named_ch  = name_value(3'(k));
      end
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.kind      = CMD_CHAR;
    cmd_push      = 1'b0;
    nonempty_next = nonempty;
    blank_next    = blank;
    if (accept) begin
      if (mode == M_ENTITY && (end_of_buffer || data_byte == CH_SEMI)) begin
        cmd_push      = 1'b1;
        cmd.end_after = end_of_buffer;
        if (ent_len > LEN_W'(ENTITY_MAX)) begin
          cmd.kind      = CMD_REPLAY;
          cmd.len       = LEN_W'(ENTITY_MAX);
          cmd.err       = 1'b1;
          nonempty_next = 1'b1;
          blank_next    = 1'b0;
        end else if (named_hit) begin
          cmd.data      = named_ch;
          nonempty_next = 1'b1;
          blank_next    = blank && is_blank(named_ch);
        end else if (is_num) begin
          if (has_digit && !acc[31]) begin
            cmd.data      = acc[7:0];
            nonempty_next = 1'b1;
            blank_next    = blank && is_blank(acc[7:0]);
          end else begin
            cmd.kind = CMD_ERR;
            cmd.err  = 1'b1;
          end
        end else begin
          cmd.kind      = CMD_REPLAY;
          cmd.len       = ent_len;
          nonempty_next = 1'b1;
          blank_next    = 1'b0;
        end
      end else if (mode == M_TEXT) begin
        if (end_of_buffer || data_byte == CH_LT) begin
          cmd_push = 1'b1;
          cmd.kind = CMD_END;
        end else if (data_byte != CH_AMP) begin
          cmd_push      = 1'b1;
          cmd.data      = data_byte;
          nonempty_next = 1'b1;
          blank_next    = blank && is_blank(data_byte);
        end
      end
      if (cmd_push && (cmd.kind == CMD_END || cmd.end_after)) begin
        cmd.ws        = nonempty_next && blank_next;
        nonempty_next = 1'b0;
        blank_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_TEXT;
      ent_len   <= '0;
      acc       <= '0;
      stopped   <= 1'b0;
      has_digit <= 1'b0;
      is_num    <= 1'b0;
      is_hex    <= 1'b0;
      match     <= '1;
      nonempty  <= 1'b0;
      blank     <= 1'b1;
      busy      <= 1'b0;
    end else begin
      nonempty <= nonempty_next;
      blank    <= blank_next;
      if (replay_done) begin
        busy <= 1'b0;
      end
      if (cmd_push && cmd.kind == CMD_REPLAY) begin
        busy <= 1'b1;
      end
      if (accept) begin
        if (mode == M_TEXT) begin
          if (!end_of_buffer && data_byte == CH_AMP) begin
            mode      <= M_ENTITY;
            ent_len   <= '0;
            acc       <= '0;
            stopped   <= 1'b0;
            has_digit <= 1'b0;
            is_num    <= 1'b0;
            is_hex    <= 1'b0;
            match     <= '1;
          end
        end else if (end_of_buffer || data_byte == CH_SEMI) begin
          mode <= M_TEXT;
        end else if (!store_go) begin
          // bytes past the bound are dropped, length marks the overflow
          ent_len <= LEN_W'(ENTITY_MAX + 1);
        end else begin
          ent_len <= LEN_W'(ent_len + 1'b1);
          if (ent_len == '0) begin
            is_num <= (data_byte == CH_HASH);
          end
          if (ent_len == LEN_W'(1)) begin
            is_hex <= (data_byte == CH_X);
          end
          for (int k = 0; k < NUM_NAMES; k++) begin
            match[k] <= match[k] && ent_len < LEN_W'(name_len(3'(k)))
                        && data_byte == name_char(3'(k), ent_len[1:0]);
          end
          if (digit_go) begin
            if (dv[4]) begin
              acc       <= acc_next;
              has_digit <= 1'b1;
            end else begin
              stopped <= 1'b1;
            end
          end
        end
      end
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

  a_store_quiet_in_replay: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !busy)
    else $error("entity store written while a replay is reading it");

endmodule

>>> hdl/xted_back.sv
// ----------------------------------------------------------------------------
// xted_back
// Takes commands from the queue and produces result transactions, replaying
// unknown or overflowed entities from the entity store.
// ----------------------------------------------------------------------------
module xted_back #(
  parameter int ENTITY_MAX = xted_pkg::ENTITY_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  xted_pkg::cmd_t                head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          replay_done,
  output logic                          ram_rd_en,
  output logic [$clog2(ENTITY_MAX)-1:0] ram_raddr,
  input  logic [7:0]                    ram_rdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic                          end_of_text,
  output logic                          node_whitespace,
  output logic                          entity_error
);
  import xted_pkg::*;

  localparam int AW = $clog2(ENTITY_MAX);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AMP,
    S_BYTE,
    S_SEMI,
    S_END
  } state_t;

  state_t           state;
  state_t           state_next;
  cmd_t             cur;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] idx_next;
  logic [LEN_W-1:0] idx_inc;
  logic             out_free;
  logic             emit;
  logic [7:0]       e_byte;
  logic             e_bv;
  logic             e_eot;
  logic             e_ws;
  logic             e_err;

  assign out_free = !out_valid || out_ready;
  assign idx_inc  = LEN_W'(idx + 1'b1);
  assign pop      = state == S_IDLE && out_free && !empty;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    emit        = 1'b0;
    e_byte      = 8'h00;
    e_bv        = 1'b0;
    e_eot       = 1'b0;
    e_ws        = 1'b0;
    e_err       = 1'b0;
    ram_rd_en   = 1'b0;
    ram_raddr   = '0;
    replay_done = 1'b0;
    case (state)
      S_IDLE: begin
        if (pop) begin
          case (head.kind)
            CMD_CHAR: begin
              emit       = 1'b1;
              e_byte     = head.data;
              e_bv       = 1'b1;
              e_err      = head.err;
              state_next = head.end_after ? S_END : S_IDLE;
            end
            CMD_ERR: begin
              emit       = 1'b1;
              e_err      = 1'b1;
              state_next = head.end_after ? S_END : S_IDLE;
            end
            CMD_END: begin
              emit  = 1'b1;
              e_eot = 1'b1;
              e_ws  = head.ws;
            end
            default: state_next = S_AMP;
          endcase
        end
      end
      S_AMP: begin
        if (out_free) begin
          emit       = 1'b1;
          e_byte     = CH_AMP;
          e_bv       = 1'b1;
          e_err      = cur.err;
          idx_next   = '0;
          ram_rd_en  = cur.len != '0;
          state_next = (cur.len != '0) ? S_BYTE : S_SEMI;
        end
      end
      S_BYTE: begin
        if (out_free) begin
          emit       = 1'b1;
          e_byte     = ram_rdata;
          e_bv       = 1'b1;
          e_err      = cur.err;
          idx_next   = idx_inc;
          // fetch the next stored byte while this one goes out
          ram_rd_en  = idx_inc != cur.len;
          ram_raddr  = idx_inc[AW-1:0];
          state_next = (idx_inc == cur.len) ? S_SEMI : S_BYTE;
        end
      end
      S_SEMI: begin
        if (out_free) begin
          emit        = 1'b1;
          e_byte      = CH_SEMI;
          e_bv        = 1'b1;
          e_err       = cur.err;
          replay_done = 1'b1;
          state_next  = cur.end_after ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (out_free) begin
          emit       = 1'b1;
          e_eot      = 1'b1;
          e_ws       = cur.ws;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    idx <= idx_next;
    if (emit) begin
      out_byte        <= e_byte;
      byte_valid      <= e_bv;
      end_of_text     <= e_eot;
      node_whitespace <= e_ws;
      entity_error    <= e_err;
    end
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_marker_carries_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_text |-> !byte_valid && !entity_error)
    else $error("end marker carries a byte or error");

  a_replay_index_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_BYTE |-> idx < cur.len)
    else $error("replay index past entity length");

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XML text entity decoder. Text bytes go in over a
// valid/ready channel from a queue of directed and randomly built text; every
// accepted byte runs through a bench-side decoder, and each decoded result is
// compared field by field with what the block hands out.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xted_pkg::*;

  localparam int          ENTITY_MAX = ENTITY_MAX_DEF;
  localparam logic [31:0] CODE_LIMIT = CODE_SAT - 32'd1;
  localparam logic [7:0]  CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [7:0] chr;
    logic       eob;
  } text_in_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       valid;
    logic       eot;
    logic       ws;
    logic       err;
  } decoded_t;

  typedef enum int {
    SEG_PLAIN, SEG_BLANK, SEG_TAG, SEG_EOB, SEG_NAMED, SEG_DEC, SEG_HEX,
    SEG_BADNUM, SEG_BIGNUM, SEG_UNKNOWN, SEG_LONG, SEG_OPEN_EOB, SEG_NOISE
  } seg_kind_t;
  localparam int N_SEG_KINDS = 13;

  logic       clk             = 1'b0;
  logic       rst             = 1'b1;
  logic       in_valid        = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte       = 8'h00;
  logic       end_of_buffer   = 1'b0;
  logic       out_valid;
  logic       out_ready       = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_text;
  logic       node_whitespace;
  logic       entity_error;

  xml_text_entity_decoder u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .end_of_buffer   (end_of_buffer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .byte_valid      (byte_valid),
    .end_of_text     (end_of_text),
    .node_whitespace (node_whitespace),
    .entity_error    (entity_error)
  );

  always #5 clk = ~clk;

  text_in_t text_stream_q[$];
  decoded_t decoded_q[$];
  string    entity_names[5] = '{"lt", "gt", "amp", "quot", "apos"};
  logic [7:0] blanks[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};

  int n_in, n_out, n_err, n_entities, n_runs, n_ent_err;

  // bench-side decoder state
  bit          in_entity;
  logic [7:0]  ent_buf[ENTITY_MAX];
  int unsigned ent_len;
  logic [31:0] code_val;
  bit          digits_done;
  int unsigned digit_cnt;
  bit          run_has_text;
  bit          run_blank;

  // ---------------------------------------------------------------- decoder
  task automatic push_result(input logic [7:0] chr, input logic valid, input logic eot,
                             input logic ws, input logic err);
    decoded_t r;
    r.chr   = chr;
    r.valid = valid;
    r.eot   = eot;
    r.ws    = ws;
    r.err   = err;
    decoded_q.push_back(r);
    if (err) n_ent_err++;
  endtask

  task automatic emit_text(input logic [7:0] b, input logic err);
    run_has_text = 1'b1;
    if (!(b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D)) run_blank = 1'b0;
    push_result(b, 1'b1, 1'b0, 1'b0, err);
  endtask

  task automatic end_text_run();
    push_result(8'h00, 1'b0, 1'b1, run_has_text && run_blank, 1'b0);
    run_has_text = 1'b0;
    run_blank    = 1'b1;
    in_entity    = 1'b0;
    n_runs++;
  endtask

  function automatic bit entity_is(input string s);
    if (ent_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++)
      if (ent_buf[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic replay_entity(input int unsigned len, input logic err);
    emit_text(CH_AMP, err);
    for (int i = 0; i < len && i < ENTITY_MAX; i++) emit_text(ent_buf[i], err);
    emit_text(CH_SEMI, err);
  endtask

  function automatic int digit_of(input logic [7:0] b, input bit hex);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (hex && b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (hex && b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  task automatic entity_push(input logic [7:0] b);
    int unsigned p;
    bit          hex;
    int          d;
    logic [63:0] acc;
    p = ent_len;
    // bytes past the bound are dropped, length marks the overflow
    if (p >= ENTITY_MAX) begin
      ent_len = ENTITY_MAX + 1;
      return;
    end
    ent_buf[p] = b;
    ent_len    = p + 1;
    if (p >= 1 && ent_buf[0] == CH_HASH) begin
      hex = (ent_buf[1] == CH_X);
      if (!(hex && p == 1) && !digits_done) begin
        d = digit_of(b, hex);
        if (d < 0) begin
          digits_done = 1'b1;
        end else begin
          if (code_val <= CODE_LIMIT) begin
            acc = 64'(code_val) * (hex ? 64'd16 : 64'd10) + 64'(d);
            code_val = (acc > 64'(CODE_LIMIT)) ? CODE_SAT : acc[31:0];
          end
          if (digit_cnt < 63) digit_cnt++;
        end
      end
    end
  endtask

  task automatic entity_close();
    int unsigned n;
    n         = ent_len;
    in_entity = 1'b0;
    n_entities++;
    if (n > ENTITY_MAX) replay_entity(ENTITY_MAX, 1'b1);
    else if (entity_is("lt"))   emit_text(CH_LT, 1'b0);
    else if (entity_is("gt"))   emit_text(CH_GT, 1'b0);
    else if (entity_is("amp"))  emit_text(CH_AMP, 1'b0);
    else if (entity_is("quot")) emit_text(CH_QUOT, 1'b0);
    else if (entity_is("apos")) emit_text(CH_APOS, 1'b0);
    else if (n >= 1 && ent_buf[0] == CH_HASH) begin
      if (digit_cnt == 0 || code_val > CODE_LIMIT) push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
      else emit_text(code_val[7:0], 1'b0);
    end else replay_entity(n, 1'b0);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eob);
    if (eob) begin
      if (in_entity) entity_close();
      end_text_run();
    end else if (in_entity) begin
      if (b == CH_SEMI) entity_close();
      else entity_push(b);
    end else if (b == CH_LT) begin
      end_text_run();
    end else if (b == CH_AMP) begin
      in_entity   = 1'b1;
      ent_len     = 0;
      code_val    = '0;
      digits_done = 1'b0;
      digit_cnt   = 0;
    end else begin
      emit_text(b, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] b, input logic eob);
    text_in_t t;
    t.chr = b;
    t.eob = eob;
    text_stream_q.push_back(t);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    while (r == a || r == b) r = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic add_segment(input seg_kind_t k);
    int    n;
    string s;
    case (k)
      SEG_PLAIN: begin
        repeat ($urandom_range(1, 6)) push_byte(rand_byte_except(CH_AMP, CH_LT), 1'b0);
      end
      SEG_BLANK: begin
        repeat ($urandom_range(1, 4)) push_byte(blanks[$urandom_range(0, 3)], 1'b0);
      end
      SEG_TAG:   push_byte(CH_LT, 1'b0);
      SEG_EOB:   push_byte(8'($urandom_range(0, 255)), 1'b1);
      SEG_NAMED: push_str({"&", entity_names[$urandom_range(0, 4)], ";"});
      SEG_DEC: begin
        n = $urandom_range(0, 300);
        s = ($urandom_range(0, 3) == 0) ? $sformatf("&#%03d", n) : $sformatf("&#%0d", n);
        // digits stop at the first non-digit
        if ($urandom_range(0, 3) == 0) s = {s, "z7"};
        push_str({s, ";"});
      end
      SEG_HEX: begin
        s = $sformatf("%0h", $urandom_range(0, 'hfff));
        for (int i = 0; i < s.len(); i++)
          if (s[i] >= "a" && $urandom_range(0, 1)) s.putc(i, s[i] - 8'h20);
        if ($urandom_range(0, 3) == 0) s = {s, "g1"};
        push_str({"&#x", s, ";"});
      end
      SEG_BADNUM: begin
        case ($urandom_range(0, 3))
          0:       push_str("&#;");
          1:       push_str("&#x;");
          2:       push_str("&#X41;");
          default: push_str("&#q5;");
        endcase
      end
      SEG_BIGNUM: begin
        case ($urandom_range(0, 5))
          0: push_str("&#2147483647;");
          1: push_str("&#2147483648;");
          2: push_str("&#x7fffffff;");
          3: push_str("&#x80000000;");
          4: push_str($sformatf("&#%0d%0d;", $urandom_range(10000, 99999),
                                $urandom_range(1000000, 9999999)));
          default: push_str("&#x00000000000041;");
        endcase
      end
      SEG_UNKNOWN: begin
        if ($urandom_range(0, 3) == 0) begin
          // near miss on a known name
          s = entity_names[$urandom_range(0, 4)];
          push_str({"&", s.substr(0, s.len() - 2), ";"});
        end else begin
          push_byte(CH_AMP, 1'b0);
          repeat ($urandom_range(0, 8)) push_byte(rand_byte_except(CH_SEMI, CH_SEMI), 1'b0);
          push_byte(CH_SEMI, 1'b0);
        end
      end
      SEG_LONG: begin
        push_byte(CH_AMP, 1'b0);
        repeat ($urandom_range(ENTITY_MAX - 2, ENTITY_MAX + 8))
          push_byte(rand_byte_except(CH_SEMI, CH_SEMI), 1'b0);
        if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)), 1'b1);
        else push_byte(CH_SEMI, 1'b0);
      end
      SEG_OPEN_EOB: begin
        case ($urandom_range(0, 3))
          0:       push_str({"&", entity_names[$urandom_range(0, 4)]});
          1:       push_str("&#6");
          2:       push_str("&#x");
          default: begin
            push_byte(CH_AMP, 1'b0);
            repeat ($urandom_range(0, 5)) push_byte(rand_byte_except(CH_SEMI, CH_SEMI), 1'b0);
          end
        endcase
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: push_byte(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  // ---------------------------------------------------------------- driver
  bit       in_fire;
  int       burst_left = 1;
  int       gap_left;
  text_in_t next_item;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (text_stream_q.size() > 0) begin
        next_item = text_stream_q.pop_front();
        data_byte     <= next_item.chr;
        end_of_buffer <= next_item.eob;
        in_valid      <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int rx_cycle;
  int rx_mode;
  int hold_left;
  bit hold_done;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_in >= 120) begin
        // long back-pressure so the block fills and stalls its input
        hold_left = 80;
        hold_done = 1'b1;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= (rx_cycle % 3 != 0);
          default: out_ready <= ((rx_cycle / 4) % 2 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  decoded_t want_r;

  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      decode_byte(data_byte, end_of_buffer);
      n_in++;
    end
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %0h byte_valid %0b end_of_text %0b",
               out_byte, byte_valid, end_of_text);
        n_err++;
      end else begin
        want_r = decoded_q.pop_front();
        check_field("out_byte", want_r.chr, out_byte);
        check_field("byte_valid", want_r.valid, byte_valid);
        check_field("end_of_text", want_r.eot, end_of_text);
        check_field("node_whitespace", want_r.ws, node_whitespace);
        check_field("entity_error", want_r.err, entity_error);
        n_out++;
      end
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    run_blank = 1'b1;

    // byte extremes, an empty run, a blank run, named, hex, bad and open entities
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_LT, 1'b0);
    push_byte(8'h00, 1'b1);
    push_str("&amp;");
    push_str("&#x4A;");
    push_str("&#;");
    push_str("&q");
    push_byte(8'hA5, 1'b1);
    push_str(" \t");
    push_byte(CH_LT, 1'b0);

    // every segment kind once, then a mostly well-formed random mix
    for (int i = 0; i < N_SEG_KINDS; i++) add_segment(seg_kind_t'(i));
    while (text_stream_q.size() < 260) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 22)      add_segment(SEG_PLAIN);
      else if (r < 30) add_segment(SEG_BLANK);
      else if (r < 38) add_segment(SEG_TAG);
      else if (r < 43) add_segment(SEG_EOB);
      else if (r < 58) add_segment(SEG_NAMED);
      else if (r < 66) add_segment(SEG_DEC);
      else if (r < 73) add_segment(SEG_HEX);
      else if (r < 77) add_segment(SEG_BADNUM);
      else if (r < 81) add_segment(SEG_BIGNUM);
      else if (r < 88) add_segment(SEG_UNKNOWN);
      else if (r < 90) add_segment(SEG_LONG);
      else if (r < 94) add_segment(SEG_OPEN_EOB);
      else             add_segment(SEG_NOISE);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_stream_q.size() > 0 || in_valid) @(posedge clk);
    while (decoded_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d input transactions, %0d results checked", n_in, n_out);
    $display("  %0d text runs, %0d entities, %0d results flagged as entity errors",
             n_runs, n_entities, n_ent_err);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout waiting for the decoder");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
